// ===== design/fct_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fct_pkg;

	localparam int REG_COUNT       = 6;
	localparam int PLANE_COUNT_DEF = 6;
	localparam int CFG_DATA_W      = 64;
	localparam int CFG_ADDR_W      = $clog2(REG_COUNT * 8);
	localparam int CFG_IDX_W       = CFG_ADDR_W - 3;

	// distance with 18 fraction bits, offset and radius folded in
	localparam int DIST_W = 36;
	localparam int PROD_W = 32;

	localparam logic [1:0] KIND_POINT  = 2'd0;
	localparam logic [1:0] KIND_SPHERE = 2'd1;
	localparam logic [1:0] KIND_BOX    = 2'd2;
	localparam logic [1:0] KIND_NONE   = 2'd3;

	typedef struct packed {
		logic s1;
		logic s2;
	} fct_adv_t;

endpackage

`default_nettype wire

// ===== design/fct_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fct_regs
	import fct_pkg::*;
(
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 psel,
	input  wire logic                                 penable,
	input  wire logic                                 pwrite,
	input  wire logic [CFG_ADDR_W-1:0]                paddr,
	input  wire logic [CFG_DATA_W-1:0]                pwdata,
	output logic      [CFG_DATA_W-1:0]                prdata,
	output logic                                      pready,
	output logic      [REG_COUNT-1:0][CFG_DATA_W-1:0] planes
);

	localparam logic [CFG_IDX_W-1:0] LAST_IDX = CFG_IDX_W'(REG_COUNT - 1);

	logic [CFG_IDX_W-1:0]  idx;
	logic                  hit;
	logic [REG_COUNT-1:0][CFG_DATA_W-1:0] planes_q;

	assign idx    = paddr[CFG_ADDR_W-1:3];
	assign hit    = (idx <= LAST_IDX);
	assign pready = 1'b1;
	assign planes = planes_q;
	assign prdata = hit ? planes_q[idx] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			planes_q <= '0;
		end else if (psel && penable && pwrite && hit) begin
			planes_q[idx] <= pwdata;
		end
	end

endmodule

`default_nettype wire

// ===== design/fct_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fct_lane
	import fct_pkg::*;
(
	input  wire logic                   clk,
	input  wire fct_adv_t               adv,
	input  wire logic [CFG_DATA_W-1:0]  plane,
	input  wire logic                   is_box,
	input  wire logic signed [15:0]     first_x,
	input  wire logic signed [15:0]     first_y,
	input  wire logic signed [15:0]     first_z,
	input  wire logic signed [15:0]     second_x,
	input  wire logic signed [15:0]     second_y,
	input  wire logic signed [15:0]     second_z,
	input  wire logic [14:0]            rad_s1,
	output logic                        pos_neg,
	output logic                        neg_neg
);

	logic signed [15:0] nx, ny, nz, off;
	logic               gx, gy, gz;
	logic signed [15:0] px, py, pz, qx, qy, qz;

	logic signed [PROD_W-1:0] ppx_s1, ppy_s1, ppz_s1;
	logic signed [PROD_W-1:0] pqx_s1, pqy_s1, pqz_s1;

	logic signed [DIST_W-1:0] dot_p, dot_q, bias, rterm;
	logic signed [DIST_W-1:0] sp_s2, sn_s2;

	assign nx  = signed'(plane[15:0]);
	assign ny  = signed'(plane[31:16]);
	assign nz  = signed'(plane[47:32]);
	assign off = signed'(plane[63:48]);

	// positive vertex takes the max where the normal is non-negative
	assign gx = is_box && !nx[15];
	assign gy = is_box && !ny[15];
	assign gz = is_box && !nz[15];

	assign px = gx ? second_x : first_x;
	assign py = gy ? second_y : first_y;
	assign pz = gz ? second_z : first_z;
	assign qx = gx ? first_x : second_x;
	assign qy = gy ? first_y : second_y;
	assign qz = gz ? first_z : second_z;

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			ppx_s1 <= nx * px;
			ppy_s1 <= ny * py;
			ppz_s1 <= nz * pz;
			pqx_s1 <= nx * qx;
			pqy_s1 <= ny * qy;
			pqz_s1 <= nz * qz;
		end
	end

	assign dot_p = DIST_W'(ppx_s1) + DIST_W'(ppy_s1) + DIST_W'(ppz_s1);
	assign dot_q = DIST_W'(pqx_s1) + DIST_W'(pqy_s1) + DIST_W'(pqz_s1);
	assign bias  = {{(DIST_W - 30){off[15]}}, off, 14'b0};
	assign rterm = signed'({{(DIST_W - 29){1'b0}}, rad_s1, 14'b0});

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			sp_s2 <= dot_p - bias + rterm;
			sn_s2 <= dot_q - bias;
		end
	end

	assign pos_neg = sp_s2[DIST_W-1];
	assign neg_neg = sn_s2[DIST_W-1];

endmodule

`default_nettype wire

// ===== design/frustum_culling_test_core.sv =====
// Frustum culling test: one point, sphere or axis-aligned box per word is
// checked against PLANE_COUNT planes; culled is 1 when it lies wholly outside.
// Input channel item_valid/item_ready carries kind, first_*, second_*,
// radius and unbounded_box. Output channel result_valid/result_ready carries
// culled, one result word per input word, in order.
// Planes are written over the APB port, 64-bit registers at 8*i (near, far,
// top, bottom, left, right); write them only while no word is in flight.
// Path: an accepted word moves through registers v_s1, v_s2 and v_s3;
// result_valid is v_s3. Throughput: one word per cycle when not stalled;
// each plane has its own lane of six 16x16 multipliers, so the rate does
// not depend on the plane count.
// Stages: vertex select and multiply, sum with offset and radius, compare
// and OR across planes into the output register.
// Reset clears all planes to zero (nothing is culled) and empties the
// pipeline. When the receiver stalls, the pipeline keeps filling bubbles
// and stops accepting only once all three stages hold words.
`timescale 1ns / 1ps
`default_nettype none

module frustum_culling_test_core
	import fct_pkg::*;
#(
	parameter int PLANE_COUNT = PLANE_COUNT_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   psel,
	input  wire logic                   penable,
	input  wire logic                   pwrite,
	input  wire logic [CFG_ADDR_W-1:0]  paddr,
	input  wire logic [CFG_DATA_W-1:0]  pwdata,
	output logic      [CFG_DATA_W-1:0]  prdata,
	output logic                        pready,
	input  wire logic                   item_valid,
	output logic                        item_ready,
	input  wire logic [1:0]             kind,
	input  wire logic signed [15:0]     first_x,
	input  wire logic signed [15:0]     first_y,
	input  wire logic signed [15:0]     first_z,
	input  wire logic signed [15:0]     second_x,
	input  wire logic signed [15:0]     second_y,
	input  wire logic signed [15:0]     second_z,
	input  wire logic [14:0]            radius,
	input  wire logic                   unbounded_box,
	output logic                        result_valid,
	input  wire logic                   result_ready,
	output logic                        culled
);

	logic [REG_COUNT-1:0][CFG_DATA_W-1:0] planes;

	fct_adv_t adv;
	logic     adv3;

	logic v_s1, v_s2, v_s3;
	logic box_s1, kill_s1, box_s2, kill_s2;
	logic [14:0] rad_s1;
	logic culled_s3;

	logic is_box, is_sph, kill;
	logic [PLANE_COUNT-1:0] pos_neg, neg_neg, hit;

	fct_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.planes  (planes)
	);

	assign adv3       = !v_s3 || result_ready;
	assign adv.s2     = !v_s2 || adv3;
	assign adv.s1     = !v_s1 || adv.s2;
	assign item_ready = adv.s1;

	assign is_box = (kind == KIND_BOX);
	assign is_sph = (kind == KIND_SPHERE);
	assign kill   = (kind == KIND_NONE) || (is_box && unbounded_box);

	for (genvar i = 0; i < PLANE_COUNT; i++) begin : g_lane
		logic [CFG_DATA_W-1:0] lane_plane;

		if (i < REG_COUNT) begin : g_reg
			assign lane_plane = planes[i];
		end else begin : g_zero
			assign lane_plane = '0;
		end

		fct_lane u_lane (
			.clk      (clk),
			.adv      (adv),
			.plane    (lane_plane),
			.is_box   (is_box),
			.first_x  (first_x),
			.first_y  (first_y),
			.first_z  (first_z),
			.second_x (second_x),
			.second_y (second_y),
			.second_z (second_z),
			.rad_s1   (rad_s1),
			.pos_neg  (pos_neg[i]),
			.neg_neg  (neg_neg[i])
		);

		assign hit[i] = pos_neg[i] && (!box_s2 || neg_neg[i]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv.s1) begin
				v_s1 <= item_valid;
			end
			if (adv.s2) begin
				v_s2 <= v_s1;
			end
			if (adv3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			box_s1  <= is_box;
			kill_s1 <= kill;
			rad_s1  <= is_sph ? radius : '0;
		end
		if (adv.s2) begin
			box_s2  <= box_s1;
			kill_s2 <= kill_s1;
		end
		if (adv3) begin
			culled_s3 <= !kill_s2 && (|hit);
		end
	end

	assign result_valid = v_s3;
	assign culled       = culled_s3;

`ifndef NO_ASSERTIONS
	a_kill_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready && (kind == KIND_NONE)) |=> (v_s1 && kill_s1))
		else $error("unknown kind not marked at stage 1");

	a_kill_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && kill_s2 && adv3) |=> (result_valid && !culled))
		else $error("never-culled word produced culled result");

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && adv.s2) |=> v_s2)
		else $error("word lost between stage 1 and stage 2");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb_frustum_culling_test_core.sv =====
`timescale 1ns / 1ps

module tb_frustum_culling_test_core;
	import fct_pkg::*;

	typedef enum int {
		PL_NEAR = 0,
		PL_FAR,
		PL_TOP,
		PL_BOTTOM,
		PL_LEFT,
		PL_RIGHT
	} plane_e;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [15:0] fx;
		logic signed [15:0] fy;
		logic signed [15:0] fz;
		logic signed [15:0] sx;
		logic signed [15:0] sy;
		logic signed [15:0] sz;
		logic [14:0]        rad;
		logic               unb;
	} prim_t;

	localparam logic signed [15:0] NORM_ONE = 16'sd16384;
	localparam logic signed [15:0] HALF     = 16'sd1600;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   psel = 1'b0;
	logic                   penable = 1'b0;
	logic                   pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0]  paddr = '0;
	logic [CFG_DATA_W-1:0]  pwdata = '0;
	logic [CFG_DATA_W-1:0]  prdata;
	logic                   pready;
	logic                   item_valid = 1'b0;
	logic                   item_ready;
	logic [1:0]             kind = KIND_POINT;
	logic signed [15:0]     first_x = '0;
	logic signed [15:0]     first_y = '0;
	logic signed [15:0]     first_z = '0;
	logic signed [15:0]     second_x = '0;
	logic signed [15:0]     second_y = '0;
	logic signed [15:0]     second_z = '0;
	logic [14:0]            radius = '0;
	logic                   unbounded_box = 1'b0;
	logic                   result_valid;
	logic                   result_ready = 1'b0;
	logic                   culled;

	logic [63:0] plane_regs [REG_COUNT];
	prim_t       prim_q [$];
	bit          culled_want_q [$];
	prim_t       cur;
	bit          want;
	bit          calm = 1'b0;
	int          gap_left = 0;
	int          stall_left = 0;
	int          n_errs = 0;
	int          n_sent = 0;
	int          n_culled = 0;
	int          n_settings = 0;

	frustum_culling_test_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.kind         (kind),
		.first_x      (first_x),
		.first_y      (first_y),
		.first_z      (first_z),
		.second_x     (second_x),
		.second_y     (second_y),
		.second_z     (second_z),
		.radius       (radius),
		.unbounded_box(unbounded_box),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.culled       (culled)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// signed distance, 18 fraction bits
	function automatic longint plane_dist(logic [63:0] pl, longint x, longint y, longint z);
		longint nx, ny, nz, off;
		nx = longint'($signed(pl[15:0]));
		ny = longint'($signed(pl[31:16]));
		nz = longint'($signed(pl[47:32]));
		off = longint'($signed(pl[63:48]));
		return nx * x + ny * y + nz * z - off * 16384;
	endfunction

	function automatic bit frustum_culls(prim_t p);
		longint r, dp, dn;
		bit hit;
		hit = 1'b0;
		r = longint'(p.rad) * 16384;
		if (p.kind == KIND_NONE || (p.kind == KIND_BOX && p.unb))
			return 1'b0;
		for (int i = 0; i < PLANE_COUNT_DEF && i < REG_COUNT; i++) begin
			case (p.kind)
				KIND_POINT: begin
					if (plane_dist(plane_regs[i], p.fx, p.fy, p.fz) < 0)
						hit = 1'b1;
				end
				KIND_SPHERE: begin
					if (plane_dist(plane_regs[i], p.fx, p.fy, p.fz) < -r)
						hit = 1'b1;
				end
				default: begin
					dp = plane_dist(plane_regs[i],
						plane_regs[i][15] ? p.fx : p.sx,
						plane_regs[i][31] ? p.fy : p.sy,
						plane_regs[i][47] ? p.fz : p.sz);
					dn = plane_dist(plane_regs[i],
						plane_regs[i][15] ? p.sx : p.fx,
						plane_regs[i][31] ? p.sy : p.fy,
						plane_regs[i][47] ? p.sz : p.fz);
					if (dp < 0 && dn < 0)
						hit = 1'b1;
				end
			endcase
		end
		return hit;
	endfunction

	function automatic logic [63:0] plane_word(logic signed [15:0] nx, logic signed [15:0] ny,
			logic signed [15:0] nz, logic signed [15:0] d);
		return {d, nz, ny, nx};
	endfunction

	function automatic logic [63:0] rand_plane();
		logic signed [15:0] n [3];
		logic signed [15:0] d;
		for (int k = 0; k < 3; k++)
			n[k] = 16'($urandom_range(0, 32768) - 16384);
		if ($urandom_range(0, 3) == 0)
			n[$urandom_range(0, 2)] = '0;
		d = 16'(int'($urandom_range(0, 4000)) - 2000);
		return {d, n[2], n[1], n[0]};
	endfunction

	function automatic logic signed [15:0] rand_coord(int span);
		if ($urandom_range(0, 7) == 0)
			return 16'($urandom);
		return 16'(int'($urandom_range(0, 2 * span)) - span);
	endfunction

	function automatic void add_prim(logic [1:0] k, logic signed [15:0] ax, logic signed [15:0] ay,
			logic signed [15:0] az, logic signed [15:0] bx, logic signed [15:0] by,
			logic signed [15:0] bz, logic [14:0] r, logic u);
		prim_t p;
		p = '{kind: k, fx: ax, fy: ay, fz: az, sx: bx, sy: by, sz: bz, rad: r, unb: u};
		prim_q.push_back(p);
	endfunction

	function automatic void add_rand_prims(int count, int span);
		prim_t p;
		logic signed [15:0] t;
		int pick;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 19);
			p.kind = (pick == 0) ? KIND_NONE : (pick < 7) ? KIND_POINT :
				(pick < 13) ? KIND_SPHERE : KIND_BOX;
			p.fx = rand_coord(span);
			p.fy = rand_coord(span);
			p.fz = rand_coord(span);
			p.sx = rand_coord(span);
			p.sy = rand_coord(span);
			p.sz = rand_coord(span);
			// well-ordered boxes mostly, inverted now and then
			if (p.kind == KIND_BOX && $urandom_range(0, 9) != 0) begin
				if (p.fx > p.sx) begin t = p.fx; p.fx = p.sx; p.sx = t; end
				if (p.fy > p.sy) begin t = p.fy; p.fy = p.sy; p.sy = t; end
				if (p.fz > p.sz) begin t = p.fz; p.fz = p.sz; p.sz = t; end
			end
			if ($urandom_range(0, 5) == 0)
				p.rad = 15'($urandom);
			else
				p.rad = 15'($urandom_range(0, span / 2));
			if (p.kind == KIND_BOX)
				p.unb = ($urandom_range(0, 7) == 0);
			else
				p.unb = 1'($urandom);
			prim_q.push_back(p);
		end
	endfunction

	task automatic apb_write(int idx, logic [63:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CFG_ADDR_W'(idx * 8);
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		plane_regs[idx] = val;
		@(negedge clk);
	endtask

	task automatic settle();
		do
			@(negedge clk);
		while (prim_q.size() != 0 || item_valid || culled_want_q.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic load_rand_planes();
		for (int i = 0; i < REG_COUNT; i++)
			apb_write(i, rand_plane());
		n_settings++;
	endtask

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && item_ready) begin
				culled_want_q.push_back(frustum_culls(cur));
				n_sent++;
			end
			if (!item_valid || item_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					item_valid <= 1'b0;
				end else if (prim_q.size() == 0) begin
					item_valid <= 1'b0;
				end else if (!calm && $urandom_range(0, 9) == 0) begin
					gap_left = $urandom_range(0, 10);
					item_valid <= 1'b0;
				end else begin
					cur = prim_q.pop_front();
					item_valid <= 1'b1;
					kind <= cur.kind;
					first_x <= cur.fx;
					first_y <= cur.fy;
					first_z <= cur.fz;
					second_x <= cur.sx;
					second_y <= cur.sy;
					second_z <= cur.sz;
					radius <= cur.rad;
					unbounded_box <= cur.unb;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && result_ready) begin
				if (culled_want_q.size() == 0) begin
					$display("%0t: result word with nothing expected, culled=%0b", $time, culled);
					n_errs++;
				end else begin
					want = culled_want_q.pop_front();
					if (culled !== want) begin
						$display("%0t: culled mismatch: expected %0b, actual %0b",
							$time, want, culled);
						n_errs++;
					end
					if (culled === 1'b1)
						n_culled++;
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				result_ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(0, 10);
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	initial begin
		logic [63:0] corner [3];
		for (int i = 0; i < REG_COUNT; i++)
			plane_regs[i] = '0;
		corner[0] = 64'hFFFF_FFFF_FFFF_FFFF;
		corner[1] = 64'h8000_8000_8000_8000;
		corner[2] = 64'h7FFF_7FFF_7FFF_7FFF;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// planes still zero: nothing culls
		add_prim(KIND_POINT, -16'sd32768, -16'sd32768, -16'sd32768, 0, 0, 0, 0, 1'b0);
		add_prim(KIND_SPHERE, 16'sd32767, 16'sd32767, 16'sd32767, 0, 0, 0, 0, 1'b0);
		add_prim(KIND_BOX, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767,
			16'sd32767, 0, 1'b0);
		settle();
		n_settings++;

		// axis-aligned cube, half size 100.0
		apb_write(PL_NEAR,   plane_word(0, 0, NORM_ONE, -HALF));
		apb_write(PL_FAR,    plane_word(0, 0, -NORM_ONE, -HALF));
		apb_write(PL_TOP,    plane_word(0, -NORM_ONE, 0, -HALF));
		apb_write(PL_BOTTOM, plane_word(0, NORM_ONE, 0, -HALF));
		apb_write(PL_LEFT,   plane_word(NORM_ONE, 0, 0, -HALF));
		apb_write(PL_RIGHT,  plane_word(-NORM_ONE, 0, 0, -HALF));
		n_settings++;
		add_prim(KIND_POINT, 0, 0, 0, 0, 0, 0, 0, 1'b0);
		add_prim(KIND_POINT, 16'sd1600, 0, 0, 0, 0, 0, 0, 1'b0);
		add_prim(KIND_POINT, 16'sd1601, 0, 0, 0, 0, 0, 0, 1'b0);
		add_prim(KIND_POINT, 0, -16'sd1601, 0, 0, 0, 0, 0, 1'b0);
		add_prim(KIND_POINT, 0, 0, 16'sd1601, 0, 0, 0, 0, 1'b0);
		add_prim(KIND_POINT, -16'sd32768, -16'sd32768, -16'sd32768, 0, 0, 0, 0, 1'b0);
		add_prim(KIND_POINT, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd5, -16'sd9,
			16'sd3, 15'h7FFF, 1'b1);
		add_prim(KIND_SPHERE, 16'sd1700, 0, 0, 0, 0, 0, 15'd100, 1'b0);
		add_prim(KIND_SPHERE, 16'sd1701, 0, 0, 0, 0, 0, 15'd100, 1'b0);
		add_prim(KIND_SPHERE, 16'sd32767, 0, 0, 0, 0, 0, 15'h7FFF, 1'b0);
		add_prim(KIND_SPHERE, -16'sd32768, -16'sd32768, -16'sd32768, 0, 0, 0, 0, 1'b0);
		add_prim(KIND_SPHERE, 0, 16'sd3000, 0, 0, 0, 0, 15'd10, 1'b1);
		add_prim(KIND_SPHERE, 0, 0, -16'sd1700, 0, 0, 0, 15'h7FFF, 1'b0);
		add_prim(KIND_BOX, -16'sd100, -16'sd100, -16'sd100, 16'sd100, 16'sd100, 16'sd100,
			0, 1'b0);
		add_prim(KIND_BOX, 16'sd1601, 0, 0, 16'sd2000, 16'sd10, 16'sd10, 0, 1'b0);
		add_prim(KIND_BOX, 16'sd1500, 0, 0, 16'sd2000, 16'sd10, 16'sd10, 0, 1'b0);
		add_prim(KIND_BOX, 16'sd1601, 0, 0, 16'sd2000, 16'sd10, 16'sd10, 0, 1'b1);
		// inverted box, both orderings
		add_prim(KIND_BOX, 16'sd2000, 0, 0, 16'sd1601, 16'sd10, 16'sd10, 0, 1'b0);
		add_prim(KIND_BOX, 16'sd1700, 16'sd50, 16'sd50, -16'sd1700, -16'sd50, -16'sd50,
			0, 1'b0);
		add_prim(KIND_BOX, -16'sd32768, -16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767,
			16'sd32767, 0, 1'b0);
		add_prim(KIND_BOX, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767,
			16'sd32767, 0, 1'b0);
		add_prim(KIND_NONE, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767,
			16'sd32767, 0, 1'b0);
		settle();

		for (int s = 0; s < 4; s++) begin
			load_rand_planes();
			add_rand_prims(250, 3000);
			settle();
		end

		for (int s = 0; s < 4; s++) begin
			for (int i = 0; i < REG_COUNT; i++)
				apb_write(i, (s < 3) ? corner[s] : {$urandom, $urandom});
			n_settings++;
			add_rand_prims(50, 32767);
			settle();
		end

		// back-to-back tail, no gaps and no stalls
		load_rand_planes();
		calm = 1'b1;
		add_rand_prims(400, 3000);
		settle();
		repeat (8) @(negedge clk);

		$display("checked %0d primitives (%0d culled) over %0d plane settings",
			n_sent, n_culled, n_settings);
		if (n_errs == 0)
			$display("tb_frustum_culling_test_core passed");
		else
			$display("tb_frustum_culling_test_core failed");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("timeout after %0d of %0d words checked", n_sent - culled_want_q.size(),
			n_sent);
		$display("tb_frustum_culling_test_core failed");
		$finish;
	end

endmodule

// ===== sim.f =====
design/fct_pkg.sv
design/fct_regs.sv
design/fct_lane.sv
design/frustum_culling_test_core.sv
tb/sv/tb_frustum_culling_test_core.sv
